[design/hcfa_pkg.sv]
// package for the hit cluster feature accumulator: types, sizes and energy coefficients
package hcfa_pkg;

    localparam int MaxHits   = 4096;
    localparam int CountW    = 13;
    localparam int PosW      = 20;
    localparam int SumPosW   = 32;
    localparam int TimeW     = 24;
    localparam int SumTimeW  = 36;
    localparam int LayerW    = 8;
    localparam int DivW      = 36;
    localparam int DivLast   = DivW + 1;
    localparam int QuoCntW   = 6;

    typedef enum logic [1:0] {
        TM_MEAN = 2'd0,
        TM_MAX  = 2'd1,
        TM_MIN  = 2'd2,
        TM_ZERO = 2'd3
    } timing_mode_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_Z,
        ST_DIV_T,
        ST_POLY_C2,
        ST_POLY_C1,
        ST_POLY_MN,
        ST_POLY_ADD,
        ST_ECNT,
        ST_EACC,
        ST_ERND,
        ST_OUT
    } state_t;

    // coefficients signed 48-bit in q32, rows per threshold, columns constant/linear/quadratic
    function automatic logic signed [47:0] coef(input logic [1:0] t, input logic [1:0] k);
        logic signed [47:0] c;
        begin
            c = '0;
            case ({t, k})
                4'b0000: c = 48'sd10904002827798;
                4'b0001: c = 48'sd9520637760;
                4'b0010: c = -48'sd4468950;
                4'b0100: c = 48'sd21313369679023;
                4'b0101: c = -48'sd1186079257;
                4'b0110: c = -48'sd42430;
                4'b1000: c = 48'sd30206205650728;
                4'b1001: c = 48'sd3606004074;
                4'b1010: c = 48'sd9108701;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

[design/hit_cluster_feature_accumulator_top.sv]
// top level: hit accumulation and iterative cluster finishing
// flow: hits are accumulated while s_ready is high; after the last hit four divisions share one divider,
// then a horner polynomial and weighted sum per threshold plus a rounding step give the energy
// handshake: s_ready stays low from the last hit until the result is taken; reset: aresetn
// synchronous active low clears the accumulators, timing_mode and the sequencer
module hit_cluster_feature_accumulator_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [19:0]  s_pos_x,
    input  logic signed [19:0]  s_pos_y,
    input  logic signed [19:0]  s_pos_z,
    input  logic [7:0]          s_hit_layer,
    input  logic [1:0]          s_threshold,
    input  logic [23:0]         s_hit_time,
    input  logic                s_last_hit,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [19:0]  m_mean_x,
    output logic signed [19:0]  m_mean_y,
    output logic signed [19:0]  m_mean_z,
    output logic [23:0]         m_cluster_time,
    output logic [7:0]          m_min_layer,
    output logic [7:0]          m_max_layer,
    output logic [12:0]         m_count_low,
    output logic [12:0]         m_count_mid,
    output logic [12:0]         m_count_high,
    output logic signed [31:0]  m_energy,
    output logic                m_bad_threshold
);
    import hcfa_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] tmode_reg;

    logic [CountW-1:0] hit_cnt_reg, low_cnt_reg, mid_cnt_reg, high_cnt_reg;
    logic signed [SumPosW-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [SumTimeW-1:0] sum_t_reg;
    logic [TimeW-1:0] tmin_reg, tmax_reg;
    logic [LayerW-1:0] lmin_reg, lmax_reg;
    logic bad_reg;

    // shared restoring divider on magnitudes
    logic [DivW-1:0] quo_reg, rem_reg;
    logic [QuoCntW-1:0] dcnt_reg;
    logic dneg_reg;
    logic [DivW:0] trial;
    logic [CountW-1:0] divisor;

    // shared multiplier for the energy, polynomial in horner form
    logic [1:0] thr_reg;
    logic signed [61:0] prod_reg;
    logic signed [63:0] poly_reg;
    logic signed [63:0] pq32_reg;
    logic signed [79:0] eacc_reg;
    logic signed [47:0] mul_a;
    logic signed [CountW:0] mul_b;
    logic signed [61:0] mul_p;

    logic accept, take_hit;
    logic signed [63:0] rpoly;
    logic signed [79:0] racc;
    logic signed [79:0] esat;

    assign accept   = s_valid && s_ready;
    assign take_hit = accept && (hit_cnt_reg < CountW'(MaxHits));
    assign s_ready  = (state_reg == ST_ACC);
    assign divisor  = (hit_cnt_reg == '0) ? CountW'(1) : hit_cnt_reg;
    assign trial    = {rem_reg, quo_reg[DivW-1]} - {{(DivW+1-CountW){1'b0}}, divisor};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC:      if (accept && s_last_hit) state_next = ST_DIV_X;
            ST_DIV_X:    if (dcnt_reg == QuoCntW'(DivLast)) state_next = ST_DIV_Y;
            ST_DIV_Y:    if (dcnt_reg == QuoCntW'(DivLast)) state_next = ST_DIV_Z;
            ST_DIV_Z:    if (dcnt_reg == QuoCntW'(DivLast)) state_next = ST_DIV_T;
            ST_DIV_T:    if (dcnt_reg == QuoCntW'(DivLast)) state_next = ST_POLY_C2;
            ST_POLY_C2:  state_next = ST_POLY_C1;
            ST_POLY_C1:  state_next = ST_POLY_MN;
            ST_POLY_MN:  state_next = ST_POLY_ADD;
            ST_POLY_ADD: state_next = ST_ECNT;
            ST_ECNT:     state_next = ST_EACC;
            ST_EACC:     state_next = (thr_reg == 2'd2) ? ST_ERND : ST_POLY_C2;
            ST_ERND:     state_next = ST_OUT;
            ST_OUT:      if (m_ready) state_next = ST_ACC;
            default:     state_next = ST_ACC;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POLY_C2: begin
                mul_a = coef(thr_reg, 2'd2);
                mul_b = {1'b0, hit_cnt_reg};
            end
            ST_POLY_MN: begin
                mul_a = poly_reg[47:0];
                mul_b = {1'b0, hit_cnt_reg};
            end
            ST_ECNT: begin
                mul_a = pq32_reg[47:0];
                mul_b = {1'b0, (thr_reg == 2'd0) ? low_cnt_reg
                             : (thr_reg == 2'd1) ? mid_cnt_reg : high_cnt_reg};
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // round half away from zero dropping 16 bits
    assign rpoly = poly_reg[63] ? -((-poly_reg + 64'sd32768) >>> 16)
                                : ((poly_reg + 64'sd32768) >>> 16);
    assign racc  = eacc_reg[79] ? -((-eacc_reg + 80'sd32768) >>> 16)
                                : ((eacc_reg + 80'sd32768) >>> 16);
    assign esat  = (racc > 80'sd2147483647) ? 80'sd2147483647
                 : (racc < -80'sd2147483648) ? -80'sd2147483648 : racc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            tmode_reg <= TM_MEAN;
            hit_cnt_reg <= '0;
            low_cnt_reg <= '0;
            mid_cnt_reg <= '0;
            high_cnt_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            sum_t_reg <= '0;
            tmin_reg <= '1;
            tmax_reg <= '0;
            lmin_reg <= '1;
            lmax_reg <= '0;
            bad_reg <= 1'b0;
            dcnt_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) tmode_reg <= cfg_wdata;
            if (take_hit) begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
                sum_x_reg <= sum_x_reg + SumPosW'(s_pos_x);
                sum_y_reg <= sum_y_reg + SumPosW'(s_pos_y);
                sum_z_reg <= sum_z_reg + SumPosW'(s_pos_z);
                sum_t_reg <= sum_t_reg + SumTimeW'(s_hit_time);
                if (s_hit_time < tmin_reg) tmin_reg <= s_hit_time;
                if (s_hit_time > tmax_reg) tmax_reg <= s_hit_time;
                if (s_hit_layer < lmin_reg) lmin_reg <= s_hit_layer;
                if (s_hit_layer > lmax_reg) lmax_reg <= s_hit_layer;
                case (s_threshold)
                    2'd1:    low_cnt_reg <= low_cnt_reg + 1'b1;
                    2'd2:    mid_cnt_reg <= mid_cnt_reg + 1'b1;
                    2'd3:    high_cnt_reg <= high_cnt_reg + 1'b1;
                    default: bad_reg <= 1'b1;
                endcase
            end
            if (state_reg == ST_DIV_X || state_reg == ST_DIV_Y ||
                state_reg == ST_DIV_Z || state_reg == ST_DIV_T) begin
                dcnt_reg <= (dcnt_reg == QuoCntW'(DivLast)) ? '0 : dcnt_reg + 1'b1;
            end
            if (state_reg == ST_ERND) m_valid <= 1'b1;
            if (state_reg == ST_OUT && m_ready) begin
                m_valid <= 1'b0;
                hit_cnt_reg <= '0;
                low_cnt_reg <= '0;
                mid_cnt_reg <= '0;
                high_cnt_reg <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_z_reg <= '0;
                sum_t_reg <= '0;
                tmin_reg <= '1;
                tmax_reg <= '0;
                lmin_reg <= '1;
                lmax_reg <= '0;
                bad_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_ACC: begin
                thr_reg  <= 2'd0;
                eacc_reg <= '0;
            end
            ST_DIV_X, ST_DIV_Y, ST_DIV_Z, ST_DIV_T: begin
                if (dcnt_reg == '0) begin
                    // load magnitude of the dividend
                    rem_reg <= '0;
                    case (state_reg)
                        ST_DIV_X: begin
                            quo_reg  <= sum_x_reg[SumPosW-1] ? -DivW'(sum_x_reg)
                                                            : DivW'(sum_x_reg);
                            dneg_reg <= sum_x_reg[SumPosW-1];
                        end
                        ST_DIV_Y: begin
                            quo_reg  <= sum_y_reg[SumPosW-1] ? -DivW'(sum_y_reg)
                                                            : DivW'(sum_y_reg);
                            dneg_reg <= sum_y_reg[SumPosW-1];
                        end
                        ST_DIV_Z: begin
                            quo_reg  <= sum_z_reg[SumPosW-1] ? -DivW'(sum_z_reg)
                                                            : DivW'(sum_z_reg);
                            dneg_reg <= sum_z_reg[SumPosW-1];
                        end
                        default: begin
                            quo_reg  <= sum_t_reg;
                            dneg_reg <= 1'b0;
                        end
                    endcase
                end else if (dcnt_reg == QuoCntW'(DivLast)) begin
                    case (state_reg)
                        ST_DIV_X: m_mean_x <= dneg_reg ? -PosW'(quo_reg) : PosW'(quo_reg);
                        ST_DIV_Y: m_mean_y <= dneg_reg ? -PosW'(quo_reg) : PosW'(quo_reg);
                        ST_DIV_Z: m_mean_z <= dneg_reg ? -PosW'(quo_reg) : PosW'(quo_reg);
                        default: begin
                            case (tmode_reg)
                                TM_MEAN: m_cluster_time <= quo_reg[TimeW-1:0];
                                TM_MAX:  m_cluster_time <= tmax_reg;
                                TM_MIN:  m_cluster_time <= tmin_reg;
                                default: m_cluster_time <= '0;
                            endcase
                        end
                    endcase
                end else begin
                    // one quotient bit per cycle
                    if (!trial[DivW]) begin
                        rem_reg <= trial[DivW-1:0];
                        quo_reg <= {quo_reg[DivW-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[DivW-2:0], quo_reg[DivW-1]};
                        quo_reg <= {quo_reg[DivW-2:0], 1'b0};
                    end
                end
            end
            ST_POLY_C2:  prod_reg <= mul_p;
            ST_POLY_C1:  poly_reg <= 64'(prod_reg) + 64'(coef(thr_reg, 2'd1));
            ST_POLY_MN:  poly_reg <= 64'(mul_p) + 64'(coef(thr_reg, 2'd0));
            ST_POLY_ADD: pq32_reg <= rpoly;
            ST_ECNT:     prod_reg <= mul_p;
            ST_EACC: begin
                eacc_reg <= eacc_reg + 80'(prod_reg);
                thr_reg  <= thr_reg + 1'b1;
            end
            ST_ERND: begin
                m_energy        <= esat[31:0];
                m_min_layer     <= lmin_reg;
                m_max_layer     <= lmax_reg;
                m_count_low     <= low_cnt_reg;
                m_count_mid     <= mid_cnt_reg;
                m_count_high    <= high_cnt_reg;
                m_bad_threshold <= bad_reg;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_energy))
        else $error("result dropped or changed");
    a_cnt_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACC |-> (14'(low_cnt_reg) + 14'(mid_cnt_reg) + 14'(high_cnt_reg))
        <= 14'(hit_cnt_reg)) else $error("threshold counts exceed hit count");
`endif
endmodule
